/* hw/rtl/mlr_pkg.sv */
// ----------------------------------------------------------------------------
// mlr_pkg
// shared types and constants of the multichannel linear ramp block
// ----------------------------------------------------------------------------
package mlr_pkg;

  localparam int DEF_NUM_CHANNELS = 8;
  localparam int DEF_VALUE_WIDTH  = 32;

  localparam int CH_W    = 3;   // channel field width
  localparam int PORT_VW = 32;  // value field width on the ports
  localparam int LEN_W   = 24;  // ramp length in ms
  localparam int TIME_W  = 32;  // time stamp in ms
  localparam int FRAC_W  = 16;  // fraction bits of the ratio
  localparam int RATIO_W = FRAC_W + 1;  // Q0.16 plus one bit for exactly 1.0

  typedef enum logic [1:0] {
    KIND_SET  = 2'd0,
    KIND_LOAD = 2'd1,
    KIND_STOP = 2'd2,
    KIND_TICK = 2'd3
  } kind_t;

  // controller to datapath
  typedef struct packed {
    logic take;       // item transfer, latch payload
    logic set_wr;     // write current value of item channel
    logic cur_rd;     // read current value of item channel
    logic load_wr;    // write start and target of item channel
    logic run_clear;  // stop the ramp
    logic div_start;  // start ratio division
    logic idx_clear;  // channel sweep from zero
    logic idx_inc;    // next channel of sweep
    logic st_rd;      // read start and target of sweep channel
    logic diff_en;    // register direction and distance
    logic mul_en;     // register scaled step
    logic emit;       // write back and present result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    kind_t kind;
    logic  ch_ok;
    logic  running;
    logic  done;
    logic  div_busy;
    logic  idx_last;
    logic  out_free;
  } status_t;

endpackage

/* hw/rtl/mlr_if.sv */
// ----------------------------------------------------------------------------
// mlr_in_if / mlr_out_if
// valid/ready channels for ramp items and emitted channel values
// ----------------------------------------------------------------------------
interface mlr_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [2:0]         channel;
  logic signed [31:0] value;
  logic               last;
  logic [23:0]        ramp_ms;
  logic [31:0]        now_ms;

  modport source (output valid, kind, channel, value, last, ramp_ms, now_ms,
                  input ready);
  modport sink   (input valid, kind, channel, value, last, ramp_ms, now_ms,
                  output ready);
endinterface

interface mlr_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         out_channel;
  logic signed [31:0] out_value;
  logic               out_last;
  logic               finished;

  modport source (output valid, out_channel, out_value, out_last, finished,
                  input ready);
  modport sink   (input valid, out_channel, out_value, out_last, finished,
                  output ready);
endinterface

/* hw/rtl/mlr_div.sv */
// ----------------------------------------------------------------------------
// mlr_div
// serial restoring divider, ratio = elapsed * 2^16 / length, one bit a cycle
// ----------------------------------------------------------------------------
module mlr_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [mlr_pkg::LEN_W-1:0]   dividend,
  input  logic [mlr_pkg::LEN_W-1:0]   divisor,
  output logic                        busy,
  output logic [mlr_pkg::RATIO_W-1:0] quotient
);
  import mlr_pkg::*;

  localparam int CNT_W = $clog2(RATIO_W + 1);

  logic [LEN_W:0]   rem;
  logic [LEN_W:0]   rem_diff;
  logic [LEN_W:0]   rem_keep;
  logic [CNT_W-1:0] cnt;
  logic             ge;

  // dividend never exceeds divisor, so the first step gives the integer bit
  assign ge       = rem >= {1'b0, divisor};
  assign rem_diff = rem - {1'b0, divisor};
  assign rem_keep = ge ? rem_diff : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(RATIO_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= {1'b0, dividend};
    end else if (busy) begin
      rem      <= {rem_keep[LEN_W-1:0], 1'b0};
      quotient <= {quotient[RATIO_W-2:0], ge};
    end
  end

endmodule

/* hw/rtl/mlr_ctrl.sv */
// ----------------------------------------------------------------------------
// mlr_ctrl
// item sequencer: decode, ratio divide wait, per channel sweep
// ----------------------------------------------------------------------------
module mlr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             items_valid,
  output logic             items_ready,
  input  mlr_pkg::status_t status,
  output mlr_pkg::cmd_t    cmd
);
  import mlr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_LOAD_WR,
    ST_DIV,
    ST_RD,
    ST_DIFF,
    ST_MUL,
    ST_EMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   rdy;

  assign items_ready = rdy;

  always_comb begin
    cmd        = '0;
    state_next = state;
    cmd.take   = items_valid && rdy;
    case (state)
      ST_IDLE: begin
        if (cmd.take) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_next = ST_IDLE;
        case (status.kind)
          KIND_SET: begin
            cmd.set_wr    = status.ch_ok;
            cmd.run_clear = 1'b1;
          end
          KIND_LOAD: begin
            if (status.ch_ok) begin
              cmd.cur_rd = 1'b1;
              state_next = ST_LOAD_WR;
            end
          end
          KIND_STOP: begin
            cmd.run_clear = 1'b1;
          end
          KIND_TICK: begin
            if (status.running) begin
              cmd.idx_clear = 1'b1;
              if (status.done) begin
                cmd.run_clear = 1'b1;
                state_next    = ST_RD;
              end else begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
              end
            end
          end
          default: begin
            state_next = ST_IDLE;
          end
        endcase
      end
      ST_LOAD_WR: begin
        cmd.load_wr = 1'b1;
        state_next  = ST_IDLE;
      end
      ST_DIV: begin
        if (!status.div_busy) begin
          state_next = ST_RD;
        end
      end
      ST_RD: begin
        cmd.st_rd  = 1'b1;
        state_next = status.done ? ST_EMIT : ST_DIFF;
      end
      ST_DIFF: begin
        cmd.diff_en = 1'b1;
        state_next  = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.idx_last) begin
            state_next = ST_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = ST_RD;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rdy   <= 1'b1;
    end else begin
      state <= state_next;
      rdy   <= (state_next == ST_IDLE);
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    rdy |-> state == ST_IDLE)
    else $error("ready outside idle");

  a_decode_after_take: assert property (@(posedge clk) disable iff (rst)
    state == ST_DECODE |-> $past(items_valid && rdy))
    else $error("decode without item transfer");

  a_sweep_end_ready: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && status.out_free && status.idx_last) |=> rdy)
    else $error("not ready after last channel");

endmodule

/* hw/rtl/mlr_dp.sv */
// ----------------------------------------------------------------------------
// mlr_dp
// channel stores, ramp registers, ratio divider, interpolation and result reg
// ----------------------------------------------------------------------------
module mlr_dp #(
  parameter int NUM_CHANNELS = mlr_pkg::DEF_NUM_CHANNELS,
  parameter int VALUE_WIDTH  = mlr_pkg::DEF_VALUE_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [1:0]                  kind,
  input  logic [mlr_pkg::CH_W-1:0]    channel,
  input  logic [mlr_pkg::PORT_VW-1:0] value,
  input  logic                        last,
  input  logic [mlr_pkg::LEN_W-1:0]   ramp_ms,
  input  logic [mlr_pkg::TIME_W-1:0]  now_ms,
  input  mlr_pkg::cmd_t               cmd,
  output mlr_pkg::status_t            status,
  mlr_out_if.source                   results
);
  import mlr_pkg::*;

  localparam int W  = VALUE_WIDTH;
  localparam int IW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int XW = (IW > CH_W) ? IW : CH_W;

  // latched item
  kind_t             q_kind;
  logic [CH_W-1:0]   q_ch;
  logic [W-1:0]      q_val;
  logic              q_last;
  logic [LEN_W-1:0]  q_rms;
  logic [TIME_W-1:0] q_now;

  // ramp state
  logic              running;
  logic [IW-1:0]     last_idx;
  logic [TIME_W-1:0] start_time;
  logic [TIME_W:0]   end_time;
  logic [LEN_W-1:0]  ramp_len;

  // channel stores
  logic [W-1:0] cur_mem    [NUM_CHANNELS];
  logic [W-1:0] start_mem  [NUM_CHANNELS];
  logic [W-1:0] target_mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] cur_vld;
  logic [W-1:0] cur_rd;
  logic         cur_rd_vld;
  logic [W-1:0] start_rd;
  logic [W-1:0] target_rd;

  logic [IW-1:0]     idx;
  logic [XW-1:0]     ch_x;
  logic [XW-1:0]     idx_x;
  logic [IW-1:0]     ch_idx;
  logic              ch_ok;
  logic              done;
  logic [TIME_W-1:0] elapsed;

  logic               div_busy;
  logic [RATIO_W-1:0] ratio;

  logic             up;
  logic [W-1:0]     span;
  logic [W-1:0]     base;
  logic [W-1:0]     step;
  logic [W+RATIO_W-1:0] prod;
  logic [W-1:0]     lerp_val;
  logic [W-1:0]     emit_val;
  logic [IW-1:0]    cur_wa;
  logic [W-1:0]     cur_wd;
  logic             out_vld;

  assign ch_x   = XW'(q_ch);
  assign ch_idx = ch_x[IW-1:0];
  assign idx_x  = XW'(idx);
  assign ch_ok  = {{(32-CH_W){1'b0}}, q_ch} < 32'(NUM_CHANNELS);

  assign done    = ({1'b0, q_now} > end_time) || (ramp_len == '0);
  assign elapsed = (q_now >= start_time) ? q_now - start_time : '0;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      q_kind <= kind_t'(kind);
      q_ch   <= channel;
      q_val  <= W'(value);
      q_last <= last;
      q_rms  <= ramp_ms;
      q_now  <= now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running    <= 1'b0;
      last_idx   <= '0;
      start_time <= '0;
      end_time   <= '0;
      ramp_len   <= '0;
    end else begin
      if (cmd.run_clear) begin
        running <= 1'b0;
      end
      if (cmd.set_wr && q_last) begin
        last_idx <= ch_idx;
      end
      if (cmd.load_wr && q_last) begin
        last_idx   <= ch_idx;
        ramp_len   <= q_rms;
        start_time <= q_now;
        end_time   <= {1'b0, q_now} + (TIME_W+1)'(q_rms);
        running    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.idx_clear) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + 1'b1;
    end
  end

  mlr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (elapsed[LEN_W-1:0]),
    .divisor  (ramp_len),
    .busy     (div_busy),
    .quotient (ratio)
  );

  // current value store, unwritten entries read as zero
  assign cur_wa = cmd.set_wr ? ch_idx : idx;
  assign cur_wd = cmd.set_wr ? q_val : emit_val;

  always_ff @(posedge clk) begin
    if (cmd.set_wr || cmd.emit) begin
      cur_mem[cur_wa] <= cur_wd;
    end
    if (cmd.cur_rd) begin
      cur_rd <= cur_mem[ch_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_vld    <= '0;
      cur_rd_vld <= 1'b0;
    end else begin
      if (cmd.set_wr || cmd.emit) begin
        cur_vld[cur_wa] <= 1'b1;
      end
      if (cmd.cur_rd) begin
        cur_rd_vld <= cur_vld[ch_idx];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_wr) begin
      start_mem[ch_idx]  <= cur_rd_vld ? cur_rd : '0;
      target_mem[ch_idx] <= q_val;
    end
    if (cmd.st_rd) begin
      start_rd  <= start_mem[idx];
      target_rd <= target_mem[idx];
    end
  end

  // interpolation: start moved toward target by floor(|target - start| * ratio / 2^16)
  assign prod = (W+RATIO_W)'(span) * (W+RATIO_W)'(ratio);

  always_ff @(posedge clk) begin
    if (cmd.diff_en) begin
      up   <= $signed(target_rd) >= $signed(start_rd);
      span <= ($signed(target_rd) >= $signed(start_rd)) ? target_rd - start_rd
                                                         : start_rd - target_rd;
      base <= start_rd;
    end
    if (cmd.mul_en) begin
      step <= prod[W+FRAC_W-1:FRAC_W];
    end
  end

  assign lerp_val = up ? base + step : base - step;
  assign emit_val = done ? target_rd : lerp_val;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (cmd.emit) begin
      out_vld <= 1'b1;
    end else if (results.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      results.out_channel <= idx_x[CH_W-1:0];
      results.out_value   <= PORT_VW'(emit_val);
      results.out_last    <= (idx == last_idx);
      results.finished    <= done;
    end
  end

  assign results.valid = out_vld;

  assign status.kind     = q_kind;
  assign status.ch_ok    = ch_ok;
  assign status.running  = running;
  assign status.done     = done;
  assign status.div_busy = div_busy;
  assign status.idx_last = (idx == last_idx);
  assign status.out_free = !out_vld || results.ready;

  a_emit_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_vld || results.ready))
    else $error("result overwritten");

  a_div_starts: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> div_busy)
    else $error("divider did not start");

  a_ratio_range: assert property (@(posedge clk) disable iff (rst)
    cmd.mul_en |-> ratio <= RATIO_W'(1 << FRAC_W))
    else $error("ratio above one");

  a_store_in_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.set_wr || cmd.load_wr) |-> ch_ok)
    else $error("channel store write out of range");

endmodule

/* hw/rtl/multichannel_linear_ramp.sv */
// ----------------------------------------------------------------------------
// multichannel_linear_ramp
// multichannel linear ramp generator with per tick interpolated channel values
// ----------------------------------------------------------------------------
// set and stop items: decoded after transfer, then ready again
// load target items: the current value read before start is written
// ticks ending the ramp: per channel read, then write back of the target
// running ticks: serial ratio divider first, then read, distance, multiply and
//   write back per channel
// reset: synchronous, stopped, one channel, all current values read as zero
module multichannel_linear_ramp #(
  parameter int NUM_CHANNELS = mlr_pkg::DEF_NUM_CHANNELS,
  parameter int VALUE_WIDTH  = mlr_pkg::DEF_VALUE_WIDTH
) (
  input  logic      clk,
  input  logic      rst,
  mlr_in_if.sink    items,
  mlr_out_if.source results
);
  import mlr_pkg::*;

  // command and status between sequencer and datapath
  cmd_t    cmd;
  status_t status;

  // sequencer: one item at a time, ready only while idle
  mlr_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .items_valid (items.valid),
    .items_ready (items.ready),
    .status      (status),
    .cmd         (cmd)
  );

  // datapath: item latch, channel stores, divider, interpolation, result register
  mlr_dp #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .VALUE_WIDTH  (VALUE_WIDTH)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .kind    (items.kind),
    .channel (items.channel),
    .value   (items.value),
    .last    (items.last),
    .ramp_ms (items.ramp_ms),
    .now_ms  (items.now_ms),
    .cmd     (cmd),
    .status  (status),
    .results (results)
  );

endmodule
